>>> rtl/core/cbst_pkg.sv
// Shared types and constants for the processor bring-up table.
// No dependencies; used by cpu_bringup_state_table.
`timescale 1ns / 1ps

package cbst_pkg;

    // Table geometry
    localparam int MAX_CPUS     = 32;
    localparam int MAX_ATTEMPTS = 3;
    localparam int IDX_W        = $clog2(MAX_CPUS);
    localparam int CNT_W        = $clog2(MAX_CPUS + 1);

    // Item field widths
    localparam int MODE_W  = 3;
    localparam int ID_W    = 32;
    localparam int INIDX_W = 5;
    localparam int TOT_W   = 6;

    // Status word kept per entry: {status, attempts}
    localparam int ST_W   = 3;
    localparam int ATT_W  = $clog2(MAX_ATTEMPTS + 1);
    localparam int STAT_W = ST_W + ATT_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_START  = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_FINISH = 3'd2,
        MODE_BEGIN  = 3'd3,
        MODE_ONLINE = 3'd4,
        MODE_FAILED = 3'd5
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_DISCOVERED = 3'd0,
        ST_BOOT       = 3'd1,
        ST_PENDING    = 3'd2,
        ST_ONLINE     = 3'd3,
        ST_FAILED     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_START,
        S_DONE
    } t_state;

endpackage

>>> rtl/core/cbst_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cbst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/cpu_bringup_state_table.sv
// Top level of the processor bring-up table: sequencer, counters, id search.
// Depends on cbst_pkg and cbst_ram.
`timescale 1ns / 1ps

// Processor bring-up table. One item is taken at a time; o_in_stall stays high
// until its result has been loaded into the output register. Start, finish and
// unused modes go from decode straight to the result; begin-startup on a ready
// table with an in-range index adds one registered read of the status RAM. Add,
// mark-online and mark-failed walk the id RAM with a single 32-bit comparator,
// one entry per cycle, up to the first match or the table end; an add that is
// refused, skipped or overflowing does not walk. The result appears in the
// cycle the next transfer can be taken. A result held by i_out_stall does not
// block the next transfer in; the sequencer waits only when it has a second
// result to hand over. boot_cpu_id is written through the cfg channel, which
// is always ready and must only be used while no item is in flight.
module cpu_bringup_state_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cbst_pkg::ID_W-1:0]    i_cfg_data,
    // Input items
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cbst_pkg::MODE_W-1:0]  i_mode,
    input  logic [cbst_pkg::ID_W-1:0]    i_cpu_id,
    input  logic [cbst_pkg::INIDX_W-1:0] i_cpu_index,
    input  logic                         i_entry_enabled,
    input  logic                         i_table_valid,
    // Results
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_ok,
    output logic                         o_table_ready,
    output logic                         o_settled,
    output logic [cbst_pkg::TOT_W-1:0]   o_online_total,
    output logic [cbst_pkg::TOT_W-1:0]   o_cpu_total
);

    localparam int IDX_W  = cbst_pkg::IDX_W;
    localparam int CNT_W  = cbst_pkg::CNT_W;
    localparam int ID_W   = cbst_pkg::ID_W;
    localparam int ATT_W  = cbst_pkg::ATT_W;
    localparam int STAT_W = cbst_pkg::STAT_W;

    // Sequencer and control state
    cbst_pkg::t_state r_state, n_state;
    logic [ID_W-1:0]  r_boot_id;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_online, n_online;
    logic [CNT_W-1:0] r_unsettled, n_unsettled;   // entries discovered or pending
    logic             r_boot_found, n_boot_found;
    logic             r_build_err, n_build_err;
    logic             r_ready, n_ready;
    logic             r_ok, n_ok;

    // Latched item
    logic [cbst_pkg::MODE_W-1:0]  r_mode;
    logic [ID_W-1:0]              r_id;
    logic [cbst_pkg::INIDX_W-1:0] r_idx;
    logic                         r_en;
    logic                         r_tv;

    // Search walker
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_chk, n_chk;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;

    // Output register
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_ok, n_out_ok;
    logic                        r_out_ready, n_out_ready;
    logic                        r_out_settled, n_out_settled;
    logic [cbst_pkg::TOT_W-1:0]  r_out_online, n_out_online;
    logic [cbst_pkg::TOT_W-1:0]  r_out_total, n_out_total;

    // RAM ports
    logic              id_we, st_we;
    logic [IDX_W-1:0]  waddr, raddr;
    logic [ID_W-1:0]   id_wdata, id_rdata;
    logic [STAT_W-1:0] st_wdata, st_rdata;

    logic              in_accept;
    logic              out_free;
    logic              id_match;
    logic              table_full;
    logic              idx_in_range;
    cbst_pkg::t_status rd_status;
    logic [ATT_W-1:0]  rd_att;

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_state != cbst_pkg::S_IDLE);
    assign in_accept    = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign id_match     = (id_rdata == r_id);
    assign table_full   = (r_count >= CNT_W'(cbst_pkg::MAX_CPUS));
    assign idx_in_range = (int'(r_idx) < int'(r_count));
    assign rd_status    = cbst_pkg::t_status'(st_rdata[STAT_W-1:ATT_W]);
    assign rd_att       = st_rdata[ATT_W-1:0];

    // Entry storage
    cbst_ram #(.WIDTH(ID_W), .DEPTH(cbst_pkg::MAX_CPUS)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (waddr),
        .i_wdata (id_wdata),
        .i_raddr (raddr),
        .o_rdata (id_rdata)
    );

    cbst_ram #(.WIDTH(STAT_W), .DEPTH(cbst_pkg::MAX_CPUS)) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (waddr),
        .i_wdata (st_wdata),
        .i_raddr (raddr),
        .o_rdata (st_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cbst_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = cbst_pkg::S_DECODE;
                end
            end
            cbst_pkg::S_DECODE: begin
                case (cbst_pkg::t_mode'(r_mode))
                    cbst_pkg::MODE_ADD: begin
                        if (r_build_err || r_ready || !r_en || table_full) begin
                            n_state = cbst_pkg::S_DONE;
                        end else begin
                            n_state = cbst_pkg::S_SEARCH;
                        end
                    end
                    cbst_pkg::MODE_BEGIN: begin
                        if (r_ready && idx_in_range) begin
                            n_state = cbst_pkg::S_START;
                        end else begin
                            n_state = cbst_pkg::S_DONE;
                        end
                    end
                    cbst_pkg::MODE_ONLINE,
                    cbst_pkg::MODE_FAILED: n_state = cbst_pkg::S_SEARCH;
                    default:               n_state = cbst_pkg::S_DONE;
                endcase
            end
            cbst_pkg::S_SEARCH: begin
                if (!r_chk || id_match) begin
                    n_state = cbst_pkg::S_DONE;
                end
            end
            cbst_pkg::S_START: n_state = cbst_pkg::S_DONE;
            cbst_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = cbst_pkg::S_IDLE;
                end
            end
            default: n_state = cbst_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        n_count       = r_count;
        n_online      = r_online;
        n_unsettled   = r_unsettled;
        n_boot_found  = r_boot_found;
        n_build_err   = r_build_err;
        n_ready       = r_ready;
        n_ok          = r_ok;
        n_ptr         = r_ptr;
        n_chk         = r_chk;
        n_chk_idx     = r_chk_idx;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_ok      = r_out_ok;
        n_out_ready   = r_out_ready;
        n_out_settled = r_out_settled;
        n_out_online  = r_out_online;
        n_out_total   = r_out_total;
        id_we         = 1'b0;
        st_we         = 1'b0;
        waddr         = '0;
        raddr         = '0;
        id_wdata      = r_id;
        st_wdata      = '0;

        case (r_state)
            // Quick modes finish here; searches and begin-startup get their first read issued
            cbst_pkg::S_DECODE: begin
                n_ok      = 1'b0;
                n_ptr     = CNT_W'(1);
                n_chk     = (r_count != '0);
                n_chk_idx = '0;
                case (cbst_pkg::t_mode'(r_mode))
                    cbst_pkg::MODE_START: begin
                        n_count      = '0;
                        n_online     = '0;
                        n_unsettled  = '0;
                        n_boot_found = 1'b0;
                        n_ready      = 1'b0;
                        n_build_err  = !r_tv;
                        n_ok         = r_tv;
                    end
                    cbst_pkg::MODE_ADD: begin
                        // refused adds fail; skipped or overflow adds pass
                        n_ok = !(r_build_err || r_ready);
                    end
                    cbst_pkg::MODE_FINISH: begin
                        if (!r_build_err && r_boot_found && (r_count != '0)) begin
                            n_ready = 1'b1;
                            n_ok    = 1'b1;
                        end
                    end
                    cbst_pkg::MODE_BEGIN: begin
                        raddr = IDX_W'(r_idx);
                    end
                    default: begin
                    end
                endcase
            end

            // One id compare per cycle, next read issued alongside
            cbst_pkg::S_SEARCH: begin
                if (int'(r_ptr) < int'(r_count)) begin
                    raddr     = r_ptr[IDX_W-1:0];
                    n_chk     = 1'b1;
                    n_chk_idx = r_ptr[IDX_W-1:0];
                    n_ptr     = r_ptr + CNT_W'(1);
                end else begin
                    n_chk = 1'b0;
                end
                waddr = r_chk_idx;
                case (cbst_pkg::t_mode'(r_mode))
                    cbst_pkg::MODE_ADD: begin
                        if (r_chk && id_match) begin
                            n_build_err = 1'b1;
                            n_ok        = 1'b0;
                        end else if (!r_chk) begin
                            // new entry at the end of the table
                            waddr = r_count[IDX_W-1:0];
                            id_we = 1'b1;
                            st_we = 1'b1;
                            n_ok  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            if (r_id == r_boot_id) begin
                                st_wdata     = {cbst_pkg::ST_BOOT, ATT_W'(0)};
                                n_boot_found = 1'b1;
                                n_online     = CNT_W'(1);
                            end else begin
                                st_wdata    = {cbst_pkg::ST_DISCOVERED, ATT_W'(0)};
                                n_unsettled = r_unsettled + CNT_W'(1);
                            end
                        end
                    end
                    cbst_pkg::MODE_ONLINE: begin
                        if (r_chk && id_match) begin
                            if (rd_status == cbst_pkg::ST_BOOT
                                    || rd_status == cbst_pkg::ST_ONLINE) begin
                                n_ok = 1'b1;
                            end else if (rd_status == cbst_pkg::ST_PENDING) begin
                                st_we       = 1'b1;
                                st_wdata    = {cbst_pkg::ST_ONLINE, rd_att};
                                n_online    = r_online + CNT_W'(1);
                                n_unsettled = r_unsettled - CNT_W'(1);
                                n_ok        = 1'b1;
                            end
                        end
                    end
                    cbst_pkg::MODE_FAILED: begin
                        if (r_chk && id_match && rd_status == cbst_pkg::ST_PENDING) begin
                            st_we       = 1'b1;
                            st_wdata    = {cbst_pkg::ST_FAILED, rd_att};
                            n_unsettled = r_unsettled - CNT_W'(1);
                            n_ok        = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Begin startup on the entry read in decode
            cbst_pkg::S_START: begin
                waddr = IDX_W'(r_idx);
                if ((rd_status == cbst_pkg::ST_DISCOVERED
                        || rd_status == cbst_pkg::ST_FAILED)
                        && rd_att < ATT_W'(cbst_pkg::MAX_ATTEMPTS)) begin
                    st_we    = 1'b1;
                    st_wdata = {cbst_pkg::ST_PENDING, rd_att + ATT_W'(1)};
                    n_ok     = 1'b1;
                    if (rd_status == cbst_pkg::ST_FAILED) begin
                        n_unsettled = r_unsettled + CNT_W'(1);
                    end
                end
            end

            // Hand the result to the output register
            cbst_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_ok      = r_ok;
                    n_out_ready   = r_ready;
                    n_out_settled = r_ready && (r_unsettled == '0);
                    n_out_online  = cbst_pkg::TOT_W'(r_online);
                    n_out_total   = cbst_pkg::TOT_W'(r_count);
                end
            end

            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cbst_pkg::S_IDLE;
            r_boot_id    <= '0;
            r_count      <= '0;
            r_online     <= '0;
            r_unsettled  <= '0;
            r_boot_found <= 1'b0;
            r_build_err  <= 1'b0;
            r_ready      <= 1'b0;
            r_chk        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_online     <= n_online;
            r_unsettled  <= n_unsettled;
            r_boot_found <= n_boot_found;
            r_build_err  <= n_build_err;
            r_ready      <= n_ready;
            r_chk        <= n_chk;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_boot_id <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= i_mode;
            r_id   <= i_cpu_id;
            r_idx  <= i_cpu_index;
            r_en   <= i_entry_enabled;
            r_tv   <= i_table_valid;
        end
        r_ok          <= n_ok;
        r_ptr         <= n_ptr;
        r_chk_idx     <= n_chk_idx;
        r_out_ok      <= n_out_ok;
        r_out_ready   <= n_out_ready;
        r_out_settled <= n_out_settled;
        r_out_online  <= n_out_online;
        r_out_total   <= n_out_total;
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_table_ready  = r_out_ready;
    assign o_settled      = r_out_settled;
    assign o_online_total = r_out_online;
    assign o_cpu_total    = r_out_total;

`ifndef ASSERT_OFF
    // Online processors are always entries of the table
    a_online_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_online <= r_count)
        else $error("online count exceeds entry count");

    // Unsettled entries are always entries of the table
    a_unsettled_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unsettled <= r_count)
        else $error("unsettled count exceeds entry count");

    // The table is only written while an item is being worked on
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (id_we || st_we) |-> (r_state == cbst_pkg::S_SEARCH
            || r_state == cbst_pkg::S_START))
        else $error("table write outside search or startup");

    // A settled result implies a ready table
    a_settled_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_settled || o_table_ready))
        else $error("settled reported without ready table");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for cpu_bringup_state_table: build, startup and mark traffic.
// Depends on cbst_pkg and the cpu_bringup_state_table RTL; needs no files.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_ITEMS    = 270;
    localparam int NUM_PHASES     = 6;

    localparam int MODE_W   = cbst_pkg::MODE_W;
    localparam int ID_W     = cbst_pkg::ID_W;
    localparam int INIDX_W  = cbst_pkg::INIDX_W;
    localparam int TOT_W    = cbst_pkg::TOT_W;
    localparam int ATT_W    = cbst_pkg::ATT_W;
    localparam int MAX_CPUS = cbst_pkg::MAX_CPUS;

    // Spare mode codes the block must answer with ok low
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    cpu_id;
        logic [INIDX_W-1:0] cpu_index;
        logic               entry_enabled;
        logic               table_valid;
    } t_table_op;

    typedef struct packed {
        logic             ok;
        logic             table_ready;
        logic             settled;
        logic [TOT_W-1:0] online_total;
        logic [TOT_W-1:0] cpu_total;
    } t_status_report;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [ID_W-1:0]      i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode          = '0;
    logic [ID_W-1:0]      i_cpu_id        = '0;
    logic [INIDX_W-1:0]   i_cpu_index     = '0;
    logic                 i_entry_enabled = 1'b0;
    logic                 i_table_valid   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic                 o_ok;
    logic                 o_table_ready;
    logic                 o_settled;
    logic [TOT_W-1:0]     o_online_total;
    logic [TOT_W-1:0]     o_cpu_total;

    cpu_bringup_state_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_cpu_id        (i_cpu_id),
        .i_cpu_index     (i_cpu_index),
        .i_entry_enabled (i_entry_enabled),
        .i_table_valid   (i_table_valid),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_table_ready   (o_table_ready),
        .o_settled       (o_settled),
        .o_online_total  (o_online_total),
        .o_cpu_total     (o_cpu_total)
    );

    // Shadow copy of the table state
    logic [ID_W-1:0]   boot_id_q = '0;
    logic [ID_W-1:0]   ids_q   [MAX_CPUS];
    cbst_pkg::t_status stat_q  [MAX_CPUS];
    logic [ATT_W-1:0]  tries_q [MAX_CPUS];
    int                n_entries = 0;
    int                n_online  = 0;
    logic              boot_seen = 1'b0;
    logic              build_bad = 1'b0;
    logic              table_up  = 1'b0;

    t_table_op        op_q[$];
    t_status_report   status_report_q[$];
    logic [ID_W-1:0]  pool_q[$];
    t_table_op        held_op;

    int mismatches    = 0;
    int queued_ops    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int calm_send     = 0;
    int calm_recv     = 0;
    int quiet_cycles  = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Position of an id among the loaded entries, -1 if absent
    function automatic int find_cpu(logic [ID_W-1:0] id);
        for (int k = 0; k < n_entries; k++) begin
            if (ids_q[k] == id) return k;
        end
        return -1;
    endfunction

    // Apply one operation to the shadow table and return the status it reports
    function automatic t_status_report apply_table_op(t_table_op op);
        t_status_report rep;
        int             pos;
        logic           quiet;
        rep = '0;
        case (op.mode)
            cbst_pkg::MODE_START: begin
                n_entries = 0;
                n_online  = 0;
                boot_seen = 1'b0;
                table_up  = 1'b0;
                build_bad = !op.table_valid;
                rep.ok    = op.table_valid;
            end
            cbst_pkg::MODE_ADD: begin
                if (!build_bad && !table_up) begin
                    rep.ok = 1'b1;
                    if (op.entry_enabled && n_entries < MAX_CPUS) begin
                        if (find_cpu(op.cpu_id) >= 0) begin
                            build_bad = 1'b1;
                            rep.ok    = 1'b0;
                        end else begin
                            ids_q[n_entries]   = op.cpu_id;
                            tries_q[n_entries] = '0;
                            stat_q[n_entries]  = cbst_pkg::ST_DISCOVERED;
                            if (op.cpu_id == boot_id_q) begin
                                stat_q[n_entries] = cbst_pkg::ST_BOOT;
                                boot_seen = 1'b1;
                                n_online  = 1;
                            end
                            n_entries++;
                        end
                    end
                end
            end
            cbst_pkg::MODE_FINISH: begin
                if (!build_bad && boot_seen && n_entries != 0) begin
                    table_up = 1'b1;
                    rep.ok   = 1'b1;
                end
            end
            cbst_pkg::MODE_BEGIN: begin
                pos = int'(op.cpu_index);
                if (table_up && pos < n_entries &&
                    (stat_q[pos] == cbst_pkg::ST_DISCOVERED ||
                     stat_q[pos] == cbst_pkg::ST_FAILED) &&
                    tries_q[pos] < cbst_pkg::MAX_ATTEMPTS) begin
                    tries_q[pos] = tries_q[pos] + ATT_W'(1);
                    stat_q[pos]  = cbst_pkg::ST_PENDING;
                    rep.ok       = 1'b1;
                end
            end
            cbst_pkg::MODE_ONLINE: begin
                pos = find_cpu(op.cpu_id);
                if (pos >= 0) begin
                    if (stat_q[pos] == cbst_pkg::ST_BOOT ||
                        stat_q[pos] == cbst_pkg::ST_ONLINE) begin
                        rep.ok = 1'b1;
                    end else if (stat_q[pos] == cbst_pkg::ST_PENDING) begin
                        stat_q[pos] = cbst_pkg::ST_ONLINE;
                        n_online++;
                        rep.ok = 1'b1;
                    end
                end
            end
            cbst_pkg::MODE_FAILED: begin
                pos = find_cpu(op.cpu_id);
                if (pos >= 0 && stat_q[pos] == cbst_pkg::ST_PENDING) begin
                    stat_q[pos] = cbst_pkg::ST_FAILED;
                    rep.ok      = 1'b1;
                end
            end
            default: ;
        endcase
        // Settled: table up and nobody left discovered or pending
        quiet = table_up;
        for (int k = 0; k < n_entries; k++) begin
            if (stat_q[k] == cbst_pkg::ST_DISCOVERED || stat_q[k] == cbst_pkg::ST_PENDING)
                quiet = 1'b0;
        end
        rep.table_ready  = table_up;
        rep.settled      = quiet;
        rep.online_total = n_online[TOT_W-1:0];
        rep.cpu_total    = n_entries[TOT_W-1:0];
        return rep;
    endfunction

    task automatic queue_op(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                            logic [INIDX_W-1:0] idx, logic en, logic tv);
        t_table_op op;
        op.mode          = mode;
        op.cpu_id        = id;
        op.cpu_index     = idx;
        op.entry_enabled = en;
        op.table_valid   = tv;
        op_q.push_back(op);
        queued_ops++;
    endtask

    // Random id that is neither the boot id nor already in the pool
    function automatic logic [ID_W-1:0] fresh_cpu_id();
        logic [ID_W-1:0] id;
        logic            clash;
        do begin
            id    = $urandom;
            clash = (id == boot_id_q);
            foreach (pool_q[k]) if (pool_q[k] == id) clash = 1'b1;
        end while (clash);
        return id;
    endfunction

    function automatic void check_field(string name, logic [ID_W-1:0] want,
                                        logic [ID_W-1:0] got);
        if (got !== want) begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Hand-picked corner cases, run with the boot id at its reset value of zero
    task automatic queue_corner_ops();
        queue_op(MODE_SPARE_LO, $urandom, INIDX_W'($urandom), 1'b0, 1'b0);
        queue_op(MODE_SPARE_HI, '1, '1, 1'b1, 1'b1);
        queue_op(cbst_pkg::MODE_START, '0, '0, 1'b0, 1'b0);   // invalid table spoils build
        queue_op(cbst_pkg::MODE_ADD, '1, '0, 1'b1, 1'b1);     // refused on build error
        queue_op(cbst_pkg::MODE_FINISH, '0, '0, 1'b0, 1'b1);
        queue_op(cbst_pkg::MODE_START, '0, '0, 1'b0, 1'b1);
        queue_op(cbst_pkg::MODE_FINISH, '0, '0, 1'b0, 1'b1);  // no entries
        queue_op(cbst_pkg::MODE_ADD, '1, '0, 1'b1, 1'b0);
        queue_op(cbst_pkg::MODE_ADD, 32'd5, '0, 1'b0, 1'b0);  // disabled, skipped
        queue_op(cbst_pkg::MODE_FINISH, '0, '0, 1'b0, 1'b1);  // boot cpu missing
        queue_op(cbst_pkg::MODE_ONLINE, '1, '0, 1'b0, 1'b0);  // mark before ready
        queue_op(cbst_pkg::MODE_ADD, '0, '0, 1'b1, 1'b0);     // boot cpu
        queue_op(cbst_pkg::MODE_ADD, '1, '0, 1'b1, 1'b0);     // duplicate id
        queue_op(cbst_pkg::MODE_FINISH, '0, '0, 1'b0, 1'b1);
        queue_op(cbst_pkg::MODE_START, '0, '0, 1'b0, 1'b1);
        queue_op(cbst_pkg::MODE_ADD, '0, '0, 1'b1, 1'b0);
        queue_op(cbst_pkg::MODE_ADD, '1, '0, 1'b1, 1'b0);
        queue_op(cbst_pkg::MODE_FINISH, '0, '0, 1'b0, 1'b1);
        queue_op(cbst_pkg::MODE_FINISH, '0, '0, 1'b0, 1'b1);  // finish again after success
        queue_op(cbst_pkg::MODE_ADD, 32'd9, '0, 1'b1, 1'b0);  // add after ready
        queue_op(cbst_pkg::MODE_BEGIN, '0, '1, 1'b0, 1'b0);   // index out of range
        queue_op(cbst_pkg::MODE_BEGIN, '0, 5'd0, 1'b0, 1'b0); // boot cpu cannot start
        queue_op(cbst_pkg::MODE_ONLINE, '0, '0, 1'b0, 1'b0);  // boot already online
        queue_op(cbst_pkg::MODE_ONLINE, 32'd12345, '0, 1'b0, 1'b0); // unknown id
        // Exhaust the attempt budget on entry 1
        for (int k = 0; k < cbst_pkg::MAX_ATTEMPTS; k++) begin
            queue_op(cbst_pkg::MODE_BEGIN, '0, 5'd1, 1'b0, 1'b0);
            queue_op(cbst_pkg::MODE_FAILED, '1, '0, 1'b0, 1'b0);
        end
        queue_op(cbst_pkg::MODE_BEGIN, '0, 5'd1, 1'b0, 1'b0);
    endtask

    // One build with random content, followed by startup and mark traffic
    task automatic queue_bringup_session();
        int   n, boot_at, ops, live, r, pick;
        logic with_boot;
        pool_q.delete();
        n         = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
        with_boot = ($urandom_range(0, 7) != 0);
        boot_at   = $urandom_range(0, n - 1);
        for (int k = 0; k < n; k++) begin
            pool_q.push_back((with_boot && k == boot_at) ? boot_id_q : fresh_cpu_id());
        end
        queue_op(cbst_pkg::MODE_START, $urandom, INIDX_W'($urandom), 1'($urandom),
                 $urandom_range(0, 19) != 0);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 10)
                queue_op(cbst_pkg::MODE_ADD, $urandom, INIDX_W'($urandom), 1'b0,
                         1'($urandom));
            if (k > 0 && $urandom_range(0, 99) < 3)
                queue_op(cbst_pkg::MODE_ADD, pool_q[$urandom_range(0, k - 1)],
                         INIDX_W'($urandom), 1'b1, 1'($urandom));
            queue_op(cbst_pkg::MODE_ADD, pool_q[k], INIDX_W'($urandom), 1'b1, 1'($urandom));
        end
        queue_op(cbst_pkg::MODE_FINISH, $urandom, INIDX_W'($urandom), 1'($urandom),
                 1'($urandom));

        live = (n < MAX_CPUS) ? n : MAX_CPUS;
        ops  = ((n > 8) ? 40 : n * 4) + $urandom_range(0, 6);
        for (int k = 0; k < ops; k++) begin
            r    = $urandom_range(0, 99);
            pick = $urandom_range(0, live - 1);
            if (r < 45) begin
                // Startup attempt, usually answered by online or failed
                queue_op(cbst_pkg::MODE_BEGIN, $urandom, INIDX_W'(pick), 1'($urandom),
                         1'($urandom));
                r = $urandom_range(0, 99);
                if (r < 60)
                    queue_op(cbst_pkg::MODE_ONLINE, pool_q[pick], INIDX_W'($urandom),
                             1'($urandom), 1'($urandom));
                else if (r < 90)
                    queue_op(cbst_pkg::MODE_FAILED, pool_q[pick], INIDX_W'($urandom),
                             1'($urandom), 1'($urandom));
            end else if (r < 60) begin
                queue_op(cbst_pkg::MODE_ONLINE, pool_q[$urandom_range(0, n - 1)],
                         INIDX_W'($urandom), 1'($urandom), 1'($urandom));
            end else if (r < 70) begin
                queue_op(cbst_pkg::MODE_FAILED, pool_q[$urandom_range(0, n - 1)],
                         INIDX_W'($urandom), 1'($urandom), 1'($urandom));
            end else if (r < 78) begin
                queue_op(cbst_pkg::MODE_BEGIN, $urandom, INIDX_W'($urandom), 1'($urandom),
                         1'($urandom));
            end else if (r < 85) begin
                queue_op(($urandom_range(0, 1) != 0) ? cbst_pkg::MODE_ONLINE
                                                     : cbst_pkg::MODE_FAILED,
                         $urandom, INIDX_W'($urandom), 1'($urandom), 1'($urandom));
            end else if (r < 90) begin
                queue_op(cbst_pkg::MODE_ADD, $urandom, INIDX_W'($urandom), 1'b1,
                         1'($urandom));
            end else if (r < 94) begin
                queue_op(cbst_pkg::MODE_FINISH, $urandom, INIDX_W'($urandom), 1'($urandom),
                         1'($urandom));
            end else begin
                // Noise: any mode, spare codes and stray starts included
                queue_op(MODE_W'($urandom), $urandom, INIDX_W'($urandom), 1'($urandom),
                         1'($urandom));
            end
        end
    endtask

    // Block is idle once nothing is queued, offered or outstanding
    task automatic wait_drained();
        while (op_q.size() != 0 || i_in_valid || status_report_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_boot_id(logic [ID_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        boot_id_q = value;
    endtask

    // Driver: offer queued ops, predict each one on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                status_report_q.push_back(apply_table_op(held_op));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (calm_send > 0) calm_send--;
                else if ($urandom_range(0, 149) == 0) calm_send = $urandom_range(20, 80);
                if (op_q.size() != 0 &&
                    (calm_send > 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
                    held_op          = op_q.pop_front();
                    i_mode          <= held_op.mode;
                    i_cpu_id        <= held_op.cpu_id;
                    i_cpu_index     <= held_op.cpu_index;
                    i_entry_enabled <= held_op.entry_enabled;
                    i_table_valid   <= held_op.table_valid;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_status_report want;
        if (o_out_valid && !i_out_stall && i_rst_n) begin
            if (status_report_q.size() == 0) begin
                $display("%0t unexpected result: expected none, got ok=%0b ready=%0b",
                         $time, o_ok, o_table_ready);
                mismatches++;
            end else begin
                want = status_report_q.pop_front();
                check_field("ok", ID_W'(want.ok), ID_W'(o_ok));
                check_field("table_ready", ID_W'(want.table_ready), ID_W'(o_table_ready));
                check_field("settled", ID_W'(want.settled), ID_W'(o_settled));
                check_field("online_total", ID_W'(want.online_total),
                            ID_W'(o_online_total));
                check_field("cpu_total", ID_W'(want.cpu_total), ID_W'(o_cpu_total));
            end
        end
        if (calm_recv > 0) calm_recv--;
        else if ($urandom_range(0, 149) == 0) calm_recv = $urandom_range(20, 80);
        i_out_stall <= i_rst_n && calm_recv == 0 && ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[cpu_bringup_state_table] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Phases: corner cases first, then random sessions under each boot id and idle pattern
    initial begin : main_seq
        int phase_end;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                wait_drained();
                case (p)
                    1:       write_boot_id('1);
                    3:       write_boot_id('0);
                    default: write_boot_id($urandom);
                endcase
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            if (p == 0) queue_corner_ops();
            phase_end = queued_ops + PHASE_ITEMS;
            while (queued_ops < phase_end) queue_bringup_session();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[cpu_bringup_state_table] OK");
        end else begin
            $display("[cpu_bringup_state_table] ERROR");
        end
        $finish;
    end

endmodule

>>> cpu_bringup_state_table.f
rtl/core/cbst_pkg.sv
rtl/core/cbst_ram.sv
rtl/core/cpu_bringup_state_table.sv
bench/tb_top.sv
